>>> sv/olt_pkg.sv
// Shared types and constants for the ordered list table.
// No dependencies; imported by ordered_list_table.
`timescale 1ns / 1ps
`default_nettype none

package olt_pkg;

  localparam int OLT_DEPTH = 16;  // default list capacity
  localparam int ITEM_W    = 32;  // width of one stored value
  localparam int ACTION_W  = 3;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 5;   // width of the reported entry count

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD_HEAD  = 3'd0,
    ACT_ADD_TAIL  = 3'd1,
    ACT_DEL_HEAD  = 3'd2,
    ACT_DEL_TAIL  = 3'd3,
    ACT_DEL_VALUE = 3'd4,
    ACT_SEARCH    = 3'd5,
    ACT_CLEAR     = 3'd6
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_SHIFT = 2'd2
  } state_t;

endpackage

`default_nettype wire

>>> sv/olt_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module olt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> sv/ordered_list_table.sv
// Ordered list table: top level with the ring pointers and the command sequencer.
// Depends on olt_pkg and olt_ram.
//
//   channel   | handshake            | payload
//   ----------+----------------------+-----------------------------------
//   command   | start / busy         | action, item_value
//   result    | done (1-cycle pulse) | status, found, entry_count
//
// Add head/tail, delete head/tail, clear, the unused action code and a search
// or delete-value on an empty list raise done in the cycle right after the
// accepting edge. A search or delete-value steps through the entries in order
// (the single RAM read port streams one entry a cycle), and a delete-value then
// moves each later entry up to close the gap (one RAM write a cycle). For those
// two on a non-empty list, busy stays high from the cycle after the accept until
// the done cycle, in which the next command can already be taken. Reset (rst,
// synchronous) empties the list at once; the RAM needs no clearing pass since
// only held entries are read. done cannot be stalled by the receiver.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_table
  import olt_pkg::*;
#(
  parameter int DEPTH = OLT_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [ACTION_W-1:0]        action,
  input  wire logic signed [ITEM_W-1:0]   item_value,
  output logic                            done,
  output logic      [STATUS_W-1:0]        status,
  output logic                            found,
  output logic      [COUNT_W-1:0]         entry_count
);

  localparam int IW = $clog2(DEPTH);        // physical RAM index
  localparam int CW = $clog2(DEPTH + 1);    // count / logical index
  localparam int SW = CW + 1;               // head + logical sum
  localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;

  // Map a logical position (0 = head) to a RAM address on the ring.
  // The sum stays below twice DEPTH, so one conditional subtract wraps it.
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] h, input logic [CW-1:0] l);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(l);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[IW-1:0];
  endfunction

  state_t            state, state_next;
  logic [IW-1:0]     hd, hd_next;          // RAM address of the head entry
  logic [CW-1:0]     cnt, cnt_next;        // entries held
  logic [CW-1:0]     idx, idx_next;        // logical position under work
  logic [ACTION_W-1:0] act_q, act_next;
  logic [ITEM_W-1:0] val_q, val_next;
  logic              done_next;
  status_t           res_status, res_status_next;
  logic              res_found, res_found_next;
  logic [COUNT_W-1:0] res_count;
  logic [EW-1:0]     cnt_ext;

  logic              we;
  logic [IW-1:0]     wa, ra;
  logic [ITEM_W-1:0] wd, rdata;

  logic [IW-1:0]     hd_dec, hd_inc;
  logic [CW-1:0]     cnt_m1, idx_p1, idx_p2;
  logic              is_full, is_empty;

  olt_ram #(
    .WIDTH (ITEM_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (we),
    .wr_addr (wa),
    .wr_data (wd),
    .rd_addr (ra),
    .rd_data (rdata)
  );

  assign hd_dec   = (hd == '0) ? IW'(DEPTH - 1) : hd - IW'(1);
  assign hd_inc   = (hd == IW'(DEPTH - 1)) ? '0 : hd + IW'(1);
  assign cnt_m1   = cnt - CW'(1);
  assign idx_p1   = idx + CW'(1);
  assign idx_p2   = idx + CW'(2);
  assign is_full  = (cnt == CW'(DEPTH));
  assign is_empty = (cnt == '0);
  assign cnt_ext  = EW'(cnt_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      hd    <= '0;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      hd    <= hd_next;
      cnt   <= cnt_next;
      done  <= done_next;
    end
  end

  // Working and result payload: no reset needed.
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    act_q      <= act_next;
    val_q      <= val_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
    if (done_next) begin
      res_count <= cnt_ext[COUNT_W-1:0];
    end
  end

  always_comb begin
    state_next      = state;
    hd_next         = hd;
    cnt_next        = cnt;
    idx_next        = idx;
    act_next        = act_q;
    val_next        = val_q;
    done_next       = 1'b0;
    res_status_next = res_status;
    res_found_next  = res_found;
    we              = 1'b0;
    wa              = phys(hd, idx);
    wd              = item_value;
    ra              = hd;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          act_next        = action;
          val_next        = item_value;
          done_next       = 1'b1;
          res_status_next = ST_DONE;
          res_found_next  = 1'b0;
          unique case (action)
            ACT_ADD_HEAD: begin
              if (is_full) begin
                res_status_next = ST_FULL;
              end else begin
                // step the head back one slot and write there
                we       = 1'b1;
                wa       = hd_dec;
                hd_next  = hd_dec;
                cnt_next = cnt + CW'(1);
              end
            end
            ACT_ADD_TAIL: begin
              if (is_full) begin
                res_status_next = ST_FULL;
              end else begin
                we       = 1'b1;
                wa       = phys(hd, cnt);
                cnt_next = cnt + CW'(1);
              end
            end
            ACT_DEL_HEAD: begin
              if (is_empty) begin
                res_status_next = ST_EMPTY;
              end else begin
                hd_next  = hd_inc;
                cnt_next = cnt_m1;
              end
            end
            ACT_DEL_TAIL: begin
              if (is_empty) begin
                res_status_next = ST_EMPTY;
              end else begin
                cnt_next = cnt_m1;
              end
            end
            ACT_DEL_VALUE, ACT_SEARCH: begin
              if (is_empty) begin
                res_status_next = ST_NOT_FOUND;
              end else begin
                // read the head now, compare it next cycle
                done_next  = 1'b0;
                idx_next   = '0;
                ra         = hd;
                state_next = S_SCAN;
              end
            end
            ACT_CLEAR: begin
              cnt_next = '0;
            end
            default: begin
              // unused code: report done, change nothing
            end
          endcase
        end
      end

      S_SCAN: begin
        // rdata holds position idx; fetch the next one meanwhile
        ra = phys(hd, idx_p1);
        if (rdata == val_q) begin
          if (act_q == ACT_SEARCH) begin
            done_next       = 1'b1;
            res_status_next = ST_DONE;
            res_found_next  = 1'b1;
            state_next      = S_IDLE;
          end else if (idx == cnt_m1) begin
            // match is the tail: nothing to move
            cnt_next        = cnt_m1;
            done_next       = 1'b1;
            res_status_next = ST_DONE;
            res_found_next  = 1'b1;
            state_next      = S_IDLE;
          end else begin
            // position idx+1 is already being read: start closing the gap
            state_next = S_SHIFT;
          end
        end else if (idx == cnt_m1) begin
          done_next       = 1'b1;
          res_status_next = ST_NOT_FOUND;
          res_found_next  = 1'b0;
          state_next      = S_IDLE;
        end else begin
          idx_next = idx_p1;
        end
      end

      S_SHIFT: begin
        // rdata holds position idx+1: move it up to idx. The read two ahead
        // never touches a slot written in this pass, so no forwarding.
        we = 1'b1;
        wa = phys(hd, idx);
        wd = rdata;
        ra = phys(hd, idx_p2);
        if (idx_p1 == cnt_m1) begin
          cnt_next        = cnt_m1;
          done_next       = 1'b1;
          res_status_next = ST_DONE;
          res_found_next  = 1'b1;
          state_next      = S_IDLE;
        end else begin
          idx_next = idx_p1;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy        = (state != S_IDLE);
  assign status      = res_status;
  assign found       = res_found;
  assign entry_count = res_count;

endmodule

`default_nettype wire
